/* hdl/gic_pkg.sv */
// Shared types and constants of the gamepad input conditioner.
`default_nettype none
package gic_pkg;

    localparam logic [7:0]  TRIG_THRESH_RESET = 8'd20;
    localparam logic [16:0] DZ_FULL           = 17'd65536;
    localparam logic [16:0] P_ONE             = 17'd65536;
    localparam logic [14:0] Q_MAX             = 15'd32767;

    // register indexes
    localparam logic REG_TRIG_THRESH = 1'b0;
    localparam logic REG_STICK_DZ    = 1'b1;

    // trigger flag bit positions
    localparam int FLAG_HELD     = 0;
    localparam int FLAG_PRESSED  = 1;
    localparam int FLAG_RELEASED = 2;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_SQ   = 10'b00_0000_0010,
        ST_SUM  = 10'b00_0000_0100,
        ST_ROOT = 10'b00_0000_1000,
        ST_CHK  = 10'b00_0001_0000,
        ST_PDIV = 10'b00_0010_0000,
        ST_MUL  = 10'b00_0100_0000,
        ST_PREP = 10'b00_1000_0000,
        ST_AXIS = 10'b01_0000_0000,
        ST_DONE = 10'b10_0000_0000
    } stick_state_t;

    typedef struct packed {
        logic start;
        logic ack;
    } stick_ctrl_t;

    typedef struct packed {
        logic        done;
        logic [15:0] out_x;
        logic [15:0] out_y;
    } stick_stat_t;

endpackage
`default_nettype wire

/* hdl/gic_isqrt.sv */
// Bit-serial integer square root of S * 2^32, two radicand bits per cycle.
`default_nettype none
module gic_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] radicand,
    output logic             done,
    output logic [31:0]      root
);
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [31:0] rad_reg, rad_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[31:30]};
        trial     = {2'b00, root_reg, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = rem_reg;
        root_next = root_reg;
        rad_next  = rad_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            root_next = '0;
            rad_next  = radicand;
            cnt_next  = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
            root_next = {root_reg[30:0], ge};
            // low half of the radicand is zero
            rad_next  = {rad_reg[29:0], 2'b00};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

/* hdl/gic_stick.sv */
// Scaled radial deadzone of one stick: root, scale divide and two axis divides.
`default_nettype none
module gic_stick (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gic_pkg::stick_ctrl_t ctrl,
    input  wire logic signed [15:0] x,
    input  wire logic signed [15:0] y,
    input  wire logic [16:0]        dz,
    output gic_pkg::stick_stat_t    stat
);
    import gic_pkg::*;

    stick_state_t state_reg, state_next;

    logic signed [15:0] x_reg, y_reg;
    logic [16:0] dz_reg;
    logic [30:0] xx_reg, yy_reg;
    logic [31:0] lim_reg, dd_reg;
    logic [23:0] r8_reg;
    logic [32:0] rr_reg;
    logic [16:0] q_reg, p_reg;
    logic [4:0]  cnt_reg;
    logic [39:0] numx_reg, numy_reg;
    logic [24:0] remx_reg, remy_reg;
    logic [14:0] shx_reg, shy_reg, qx_reg, qy_reg;
    logic        satx_reg, saty_reg;
    logic [15:0] outx_reg, outy_reg;

    logic        sq_start;
    logic        sq_done;
    logic [31:0] sq_root;

    logic signed [31:0] xx_full, yy_full;
    logic [31:0] s_sum;
    logic [16:0] dz_rest;
    logic [31:0] r_trunc, n1;
    logic        p_ge;
    logic [32:0] p_sub;
    logic [16:0] pq;
    logic [16:0] magx, magy;
    logic [33:0] mx, my;
    logic [24:0] rshx, rshy, r8_ext;
    logic        gex, gey;

    // final quotient including the last bit taken this cycle, or Q_MAX when saturated
    function automatic logic [15:0] satx_or(input logic sat, input logic [14:0] q,
                                            input logic lastbit);
        logic [15:0] r;
        r = sat ? {1'b0, Q_MAX} : {1'b0, q[13:0], lastbit};
        return r;
    endfunction

    gic_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (s_sum),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb
    begin
        xx_full = x_reg * x_reg;
        yy_full = y_reg * y_reg;
        s_sum   = {1'b0, xx_reg} + {1'b0, yy_reg};
        dz_rest = DZ_FULL - dz_reg;
        r_trunc = {sq_root[31:8], 8'h00};
        n1      = (r_trunc > lim_reg) ? (r_trunc - lim_reg) : 32'd0;
        p_ge    = (rr_reg >= {1'b0, dd_reg});
        p_sub   = p_ge ? (rr_reg - {1'b0, dd_reg}) : rr_reg;
        pq      = {q_reg[15:0], p_ge};
        magx    = x_reg[15] ? 17'(-{x_reg[15], x_reg}) : {1'b0, x_reg};
        magy    = y_reg[15] ? 17'(-{y_reg[15], y_reg}) : {1'b0, y_reg};
        mx      = magx * p_reg;
        my      = magy * p_reg;
        r8_ext  = {1'b0, r8_reg};
        rshx    = {remx_reg[23:0], shx_reg[14]};
        rshy    = {remy_reg[23:0], shy_reg[14]};
        gex     = (rshx >= r8_ext);
        gey     = (rshy >= r8_ext);
        sq_start   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (ctrl.start) state_next = ST_SQ;
            ST_SQ:   state_next = ST_SUM;
            ST_SUM:
            begin
                if (dz_reg >= DZ_FULL || s_sum == 32'd0)
                    state_next = ST_DONE;
                else
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                sq_start = 1'b0;
                if (sq_done) state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (sq_root < lim_reg)
                    state_next = ST_DONE;
                else if ({1'b0, n1} >= {dd_reg, 1'b0})
                    state_next = ST_MUL;
                else
                    state_next = ST_PDIV;
            end
            ST_PDIV: if (cnt_reg == 5'd0) state_next = ST_MUL;
            ST_MUL:  state_next = ST_PREP;
            ST_PREP: state_next = ST_AXIS;
            ST_AXIS: if (cnt_reg == 5'd0) state_next = ST_DONE;
            ST_DONE: if (ctrl.ack) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_SUM && state_next == ST_ROOT)
            sq_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    x_reg  <= x;
                    y_reg  <= y;
                    dz_reg <= dz;
                end
            end
            ST_SQ:
            begin
                xx_reg <= xx_full[30:0];
                yy_reg <= yy_full[30:0];
            end
            ST_SUM:
            begin
                lim_reg  <= {dz_reg[16:0], 15'd0} - {15'd0, dz_reg};
                dd_reg   <= {dz_rest, 15'd0} - {15'd0, dz_rest};
                outx_reg <= '0;
                outy_reg <= '0;
            end
            ST_ROOT: ;
            ST_CHK:
            begin
                r8_reg  <= sq_root[31:8];
                rr_reg  <= {1'b0, n1};
                q_reg   <= '0;
                p_reg   <= P_ONE;
                cnt_reg <= 5'd16;
            end
            ST_PDIV:
            begin
                rr_reg  <= {p_sub[31:0], 1'b0};
                q_reg   <= pq;
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                    p_reg <= (pq > P_ONE) ? P_ONE : pq;
            end
            ST_MUL:
            begin
                numx_reg <= {mx[32:0], 7'd0} + {17'd0, r8_reg[23:1]};
                numy_reg <= {my[32:0], 7'd0} + {17'd0, r8_reg[23:1]};
            end
            ST_PREP:
            begin
                satx_reg <= (numx_reg >= {1'b0, r8_reg, 15'd0});
                saty_reg <= (numy_reg >= {1'b0, r8_reg, 15'd0});
                remx_reg <= numx_reg[39:15];
                remy_reg <= numy_reg[39:15];
                shx_reg  <= numx_reg[14:0];
                shy_reg  <= numy_reg[14:0];
                qx_reg   <= '0;
                qy_reg   <= '0;
                cnt_reg  <= 5'd14;
            end
            ST_AXIS:
            begin
                remx_reg <= gex ? (rshx - r8_ext) : rshx;
                remy_reg <= gey ? (rshy - r8_ext) : rshy;
                qx_reg   <= {qx_reg[13:0], gex};
                qy_reg   <= {qy_reg[13:0], gey};
                shx_reg  <= {shx_reg[13:0], 1'b0};
                shy_reg  <= {shy_reg[13:0], 1'b0};
                cnt_reg  <= cnt_reg - 5'd1;
            end
            ST_DONE: ;
            default: ;
        endcase
        // apply sign once the axis quotients are complete
        if (state_reg == ST_AXIS && cnt_reg == 5'd0)
        begin
            outx_reg <= x_reg[15] ? 16'(-satx_or(satx_reg, qx_reg, gex))
                                  : satx_or(satx_reg, qx_reg, gex);
            outy_reg <= y_reg[15] ? 16'(-satx_or(saty_reg, qy_reg, gey))
                                  : satx_or(saty_reg, qy_reg, gey);
        end
    end

    assign stat.done  = (state_reg == ST_DONE);
    assign stat.out_x = outx_reg;
    assign stat.out_y = outy_reg;
endmodule
`default_nettype wire

/* hdl/gamepad_input_conditioner.sv */
// Top level: config registers, button and trigger edges, two stick units.
//
//  channel | signals                              | accepted when
//  --------+--------------------------------------+-----------------------------
//  input   | in_valid, in_ready, sample fields    | in_valid & in_ready
//  output  | out_valid, out_ready, result fields  | out_valid & out_ready
//  config  | psel, penable, pwrite, paddr, pwdata | psel & penable & pwrite
//
// An item passes at most through squares and sum, a 32-step bit-serial square root
// plus its done strobe, a deadzone check, a 17-step scale divide, multiply and setup,
// a 15-step axis divide and the output load; both sticks run in parallel, and the next
// item is taken only once the previous result has moved into the output register. A
// zero vector or full deadzone goes from the sum straight to the done state.
// Reset clears the previous sample and loads the register defaults. A new item is
// taken while a result waits in the output register; the stick units hold their
// result until it moves out.
`default_nettype none
module gamepad_input_conditioner (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] buttons_now,
    input  wire logic [7:0]  trig_left,
    input  wire logic [7:0]  trig_right,
    input  wire logic signed [15:0] left_stick_x,
    input  wire logic signed [15:0] left_stick_y,
    input  wire logic signed [15:0] right_stick_x,
    input  wire logic signed [15:0] right_stick_y,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      buttons_held,
    output logic [15:0]      buttons_pressed,
    output logic [15:0]      buttons_released,
    output logic [2:0]       trig_left_flags,
    output logic [2:0]       trig_right_flags,
    output logic signed [15:0] left_out_x,
    output logic signed [15:0] left_out_y,
    output logic signed [15:0] right_out_x,
    output logic signed [15:0] right_out_y
);
    import gic_pkg::*;

    logic [7:0]  thresh_reg;
    logic [16:0] dz_reg;
    logic [15:0] prev_btn_reg;
    logic [7:0]  prev_lt_reg, prev_rt_reg;
    logic        busy_reg, busy_next;
    logic        ovalid_reg, ovalid_next;
    logic [15:0] held_reg, press_reg, rel_reg;
    logic [2:0]  ltf_reg, rtf_reg;
    logic [15:0] o_held_reg, o_press_reg, o_rel_reg;
    logic [2:0]  o_ltf_reg, o_rtf_reg;
    logic [15:0] o_lx_reg, o_ly_reg, o_rx_reg, o_ry_reg;

    logic        in_fire, out_fire, cfg_wr, load_out;
    stick_ctrl_t ctrl;
    stick_stat_t lstat, rstat;

    function automatic logic [2:0] trig_flags(input logic [7:0] now_v,
                                              input logic [7:0] prev_v,
                                              input logic [7:0] thr);
        logic [2:0] f;
        logic       h, w;
        h = (now_v > thr);
        w = (prev_v > thr);
        f = '0;
        f[FLAG_HELD]     = h;
        f[FLAG_PRESSED]  = h & ~w;
        f[FLAG_RELEASED] = ~h & w;
        return f;
    endfunction

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign in_ready = ~busy_reg;
    assign in_fire  = in_valid & ~busy_reg;
    assign out_fire = ovalid_reg & out_ready;
    assign load_out = busy_reg & lstat.done & rstat.done & (~ovalid_reg | out_ready);

    assign ctrl.start = in_fire;
    assign ctrl.ack   = load_out;

    always_comb
    begin
        unique case (paddr[2])
            REG_TRIG_THRESH: prdata = {24'd0, thresh_reg};
            REG_STICK_DZ:    prdata = {15'd0, dz_reg};
            default:         prdata = '0;
        endcase
        busy_next   = load_out ? 1'b0 : (in_fire ? 1'b1 : busy_reg);
        ovalid_next = load_out ? 1'b1 : (out_fire ? 1'b0 : ovalid_reg);
    end

    gic_stick u_left (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .x     (left_stick_x),
        .y     (left_stick_y),
        .dz    (dz_reg),
        .stat  (lstat)
    );

    gic_stick u_right (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .x     (right_stick_x),
        .y     (right_stick_y),
        .dz    (dz_reg),
        .stat  (rstat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg   <= TRIG_THRESH_RESET;
            dz_reg       <= '0;
            prev_btn_reg <= '0;
            prev_lt_reg  <= '0;
            prev_rt_reg  <= '0;
            busy_reg     <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
            if (cfg_wr)
            begin
                unique case (paddr[2])
                    REG_TRIG_THRESH: thresh_reg <= pwdata[7:0];
                    REG_STICK_DZ:    dz_reg     <= pwdata[16:0];
                    default: ;
                endcase
            end
            if (in_fire)
            begin
                prev_btn_reg <= buttons_now;
                prev_lt_reg  <= trig_left;
                prev_rt_reg  <= trig_right;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            held_reg  <= buttons_now;
            press_reg <= buttons_now & ~prev_btn_reg;
            rel_reg   <= prev_btn_reg & ~buttons_now;
            ltf_reg   <= trig_flags(trig_left, prev_lt_reg, thresh_reg);
            rtf_reg   <= trig_flags(trig_right, prev_rt_reg, thresh_reg);
        end
        if (load_out)
        begin
            o_held_reg  <= held_reg;
            o_press_reg <= press_reg;
            o_rel_reg   <= rel_reg;
            o_ltf_reg   <= ltf_reg;
            o_rtf_reg   <= rtf_reg;
            o_lx_reg    <= lstat.out_x;
            o_ly_reg    <= lstat.out_y;
            o_rx_reg    <= rstat.out_x;
            o_ry_reg    <= rstat.out_y;
        end
    end

    assign out_valid        = ovalid_reg;
    assign buttons_held     = o_held_reg;
    assign buttons_pressed  = o_press_reg;
    assign buttons_released = o_rel_reg;
    assign trig_left_flags  = o_ltf_reg;
    assign trig_right_flags = o_rtf_reg;
    assign left_out_x       = o_lx_reg;
    assign left_out_y       = o_ly_reg;
    assign right_out_x      = o_rx_reg;
    assign right_out_y      = o_ry_reg;
endmodule
`default_nettype wire
